[hw/rtl/sparkle384_sponge_hash_defines.svh]
// Assertion helpers used by the checker file.
`ifndef SPARKLE384_SPONGE_HASH_DEFINES_SVH
`define SPARKLE384_SPONGE_HASH_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define S384H_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define S384H_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/s384h_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package s384h_pkg;

    localparam int unsigned NUM_WORDS = 12;

    // Sparkle round constants
    localparam logic [31:0] ROUND_K [8] = '{
        32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738,
        32'hBB1185EB, 32'h4F7C7B57, 32'hCFBFA1C8, 32'hC2B3293D
    };

    // domain separation on word 5: padded final block vs full final block
    localparam logic [31:0] DOMAIN_SHORT = 32'h0100_0000;
    localparam logic [31:0] DOMAIN_FULL  = 32'h0200_0000;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [4:0]  FULL_BYTES = 5'd16;

    // last step index of the slim (7) and big (11) permutations
    localparam logic [3:0] SLIM_LAST = 4'd6;
    localparam logic [3:0] BIG_LAST  = 4'd10;

    localparam logic [1:0] RND_LAST   = 2'd3;
    localparam logic [1:0] CHUNK_MID  = 2'd1;
    localparam logic [1:0] CHUNK_LAST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PERM = 3'b010,
        ST_SQZ  = 3'b100
    } t_fsm;

    typedef logic [31:0] t_state [NUM_WORDS];

endpackage

`default_nettype wire

[hw/rtl/sparkle384_sponge_hash.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Width  Contents
// s_axis    in         136    tdata: block_low, block_high, byte_count; tlast: final_block
// m_axis    out        64     tdata: digest_chunk; tlast: last_chunk
//
// One shared ARX round unit (six 32-bit adders, one per branch) does one of the
// four ARX rounds of a Sparkle step per cycle; the linear layer rides on the
// fourth round. A non-final block runs the slim permutation; a final block runs
// the big permutation, then the squeeze with a slim permutation between halves.
// Reset is synchronous, active low, and clears the state to zero.
// A stalled output holds the sequencer in the squeeze until the slot frees.

module sparkle384_sponge_hash
    import s384h_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [63:0] block_low, [127:64] block_high, [132:128] byte_count, [135:133] zero
    input  wire logic [135:0] i_s_axis_tdata,
    input  wire logic         i_s_axis_tlast,   // final_block
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [63:0] digest_chunk
    output logic [63:0]       o_m_axis_tdata,
    output logic              o_m_axis_tlast    // last_chunk
);

    function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
        return (v >> n) | (v << (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] ell(input logic [31:0] v);
        return rotr(v ^ (v << 16), 5'd16);
    endfunction

    t_fsm        r_fsm, n_fsm;
    t_state      r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic [3:0]  r_last_step, n_last_step;
    logic [1:0]  r_rnd, n_rnd;
    logic [1:0]  r_chunk, n_chunk;
    logic        r_fin, n_fin;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_odata, n_odata;
    logic        r_olast, n_olast;

    t_state      w_pre, w_arx, w_lin, w_inj;
    logic        w_in_xfer;
    logic        w_out_free;

    assign o_s_axis_tready = (r_fsm == ST_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_ovalid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

    // Message injection with padding for a short final block.
    always_comb begin
        logic [127:0] blk;
        logic [4:0]   nbytes;
        logic [31:0]  m [4];
        logic [31:0]  tx, ty;
        blk    = i_s_axis_tdata[127:0];
        nbytes = (i_s_axis_tdata[132:128] > FULL_BYTES) ? FULL_BYTES
                                                        : i_s_axis_tdata[132:128];
        if (i_s_axis_tlast) begin
            for (int i = 0; i < 16; i++) begin
                if (5'(i) == nbytes) begin
                    blk[8*i +: 8] = PAD_BYTE;
                end else if (5'(i) > nbytes) begin
                    blk[8*i +: 8] = 8'h00;
                end
            end
        end
        for (int i = 0; i < 4; i++) begin
            m[i] = blk[32*i +: 32];
        end
        tx = ell(m[0] ^ m[2]);
        ty = ell(m[1] ^ m[3]);
        w_inj = r_state;
        w_inj[0] = r_state[0] ^ m[0] ^ ty;
        w_inj[1] = r_state[1] ^ m[1] ^ tx;
        w_inj[2] = r_state[2] ^ m[2] ^ ty;
        w_inj[3] = r_state[3] ^ m[3] ^ tx;
        w_inj[4] = r_state[4] ^ ty;
        w_inj[5] = r_state[5] ^ tx;
        if (i_s_axis_tlast) begin
            w_inj[5] = w_inj[5] ^ ((nbytes == FULL_BYTES) ? DOMAIN_FULL : DOMAIN_SHORT);
        end
    end

    // Shared ARX round unit: step constants on round 0, linear layer after round 3.
    always_comb begin
        logic [31:0] x, y;
        logic [4:0]  ra, rb;
        logic [31:0] tx, ty;
        w_pre = r_state;
        if (r_rnd == 2'd0) begin
            w_pre[1] = r_state[1] ^ ROUND_K[r_step[2:0]];
            w_pre[3] = r_state[3] ^ {28'd0, r_step};
        end
        unique case (r_rnd)
            2'd0: begin ra = 5'd31; rb = 5'd24; end
            2'd1: begin ra = 5'd17; rb = 5'd17; end
            2'd2: begin ra = 5'd0;  rb = 5'd31; end
            2'd3: begin ra = 5'd24; rb = 5'd16; end
        endcase
        for (int b = 0; b < 6; b++) begin
            x = w_pre[2*b];
            y = w_pre[2*b+1];
            x = x + rotr(y, ra);
            y = y ^ rotr(x, rb);
            x = x ^ ROUND_K[b];
            w_arx[2*b]   = x;
            w_arx[2*b+1] = y;
        end
        tx = ell(w_arx[0] ^ w_arx[2] ^ w_arx[4]);
        ty = ell(w_arx[1] ^ w_arx[3] ^ w_arx[5]);
        w_lin[0]  = w_arx[8]  ^ w_arx[2] ^ ty;
        w_lin[1]  = w_arx[9]  ^ w_arx[3] ^ tx;
        w_lin[2]  = w_arx[10] ^ w_arx[4] ^ ty;
        w_lin[3]  = w_arx[11] ^ w_arx[5] ^ tx;
        w_lin[4]  = w_arx[6]  ^ w_arx[0] ^ ty;
        w_lin[5]  = w_arx[7]  ^ w_arx[1] ^ tx;
        w_lin[6]  = w_arx[0];
        w_lin[7]  = w_arx[1];
        w_lin[8]  = w_arx[2];
        w_lin[9]  = w_arx[3];
        w_lin[10] = w_arx[4];
        w_lin[11] = w_arx[5];
    end

    // Sequencer
    always_comb begin
        n_fsm       = r_fsm;
        n_state     = r_state;
        n_step      = r_step;
        n_last_step = r_last_step;
        n_rnd       = r_rnd;
        n_chunk     = r_chunk;
        n_fin       = r_fin;
        n_ovalid    = r_ovalid && !i_m_axis_tready;
        n_odata     = r_odata;
        n_olast     = r_olast;
        unique case (r_fsm)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state     = w_inj;
                    n_fin       = i_s_axis_tlast;
                    n_last_step = i_s_axis_tlast ? BIG_LAST : SLIM_LAST;
                    n_step      = 4'd0;
                    n_rnd       = 2'd0;
                    n_chunk     = 2'd0;
                    n_fsm       = ST_PERM;
                end
            end
            ST_PERM: begin
                n_rnd = r_rnd + 2'd1;
                if (r_rnd == RND_LAST) begin
                    n_state = w_lin;
                    n_step  = r_step + 4'd1;
                    if (r_step == r_last_step) begin
                        n_fsm = r_fin ? ST_SQZ : ST_IDLE;
                    end
                end else begin
                    n_state = w_arx;
                end
            end
            ST_SQZ: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_chunk[0] ? {r_state[3], r_state[2]}
                                          : {r_state[1], r_state[0]};
                    n_olast  = (r_chunk == CHUNK_LAST);
                    n_chunk  = r_chunk + 2'd1;
                    if (r_chunk == CHUNK_MID) begin
                        // slim permutation between the two digest halves
                        n_last_step = SLIM_LAST;
                        n_step      = 4'd0;
                        n_rnd       = 2'd0;
                        n_fsm       = ST_PERM;
                    end else if (r_chunk == CHUNK_LAST) begin
                        for (int i = 0; i < NUM_WORDS; i++) begin
                            n_state[i] = 32'd0;
                        end
                        n_fin = 1'b0;
                        n_fsm = ST_IDLE;
                    end
                end
            end
            default: n_fsm = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_state[i] <= 32'd0;
            end
            r_step      <= 4'd0;
            r_last_step <= SLIM_LAST;
            r_rnd       <= 2'd0;
            r_chunk     <= 2'd0;
            r_fin       <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_state     <= n_state;
            r_step      <= n_step;
            r_last_step <= n_last_step;
            r_rnd       <= n_rnd;
            r_chunk     <= n_chunk;
            r_fin       <= n_fin;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

endmodule

`default_nettype wire

[hw/rtl/s384h_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sparkle384_sponge_hash_defines.svh"

module s384h_checker
    import s384h_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        i_s_tready,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [63:0] i_m_tdata,
    input wire logic        i_m_tlast
);

    logic       w_in_xfer, w_out_xfer;
    logic [1:0] r_cnt;

    assign w_in_xfer  = i_s_tvalid && i_s_tready;
    assign w_out_xfer = i_m_tvalid && i_m_tready;

    // digest chunks seen in the current message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_out_xfer) begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    `S384H_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast), "stalled digest chunk changed")
    `S384H_ASSERT_NXT(a_busy_after_in, i_clk, i_rst_n, w_in_xfer, !i_s_tready, "ready right after a block transfer")
    `S384H_ASSERT_IMP(a_last_fourth, i_clk, i_rst_n, w_out_xfer, i_m_tlast == (r_cnt == CHUNK_LAST), "last flag not on fourth chunk")
    `S384H_ASSERT_IMP(a_no_in_mid_digest, i_clk, i_rst_n, i_m_tvalid && !i_m_tlast, !i_s_tready, "input ready during digest squeeze")

endmodule

bind sparkle384_sponge_hash s384h_checker u_s384h_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);

`default_nettype wire
